// File: hw/rtl/qts_pkg.sv
// Shared types, constants and helper functions of the quintic trajectory sampler.
package qts_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int COEFF_WIDTH = 64;
   localparam int CNT_WIDTH   = $clog2(MAX_SAMPLES) + 1;

   localparam logic signed [63:0] SAT_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] COEFF_LIM = 64'((65'd1 << (COEFF_WIDTH - 1)) - 65'd1);
   localparam logic signed [63:0] OUT_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MIN   = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] U_LIMIT   = 64'sh0000_0000_8000_0000;

   // fraction bits dropped by a multiply, or gained by a divide
   typedef enum logic [2:0] {
      SHIFT_0,
      SHIFT_1,
      SHIFT_16,
      SHIFT_17,
      SHIFT_30
   } shift_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] x;
      logic [31:0]        y;
      shift_type          sh;
   } unit_req_type;

   typedef struct packed {
      logic               done;
      logic               flag;
      logic signed [63:0] value;
   } unit_rsp_type;

   typedef struct packed {
      logic               flag;
      logic signed [63:0] value;
   } sat_type;

   function automatic logic [4:0] shift_amount(shift_type sh);
      case (sh)
         SHIFT_0:  return 5'd0;
         SHIFT_1:  return 5'd1;
         SHIFT_16: return 5'd16;
         SHIFT_17: return 5'd17;
         SHIFT_30: return 5'd30;
         default:  return 5'd0;
      endcase
   endfunction

   function automatic sat_type sat_add(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] sum;
      sat_type            r;
      sum = 65'(a) + 65'(b);
      r.flag  = 1'b0;
      r.value = sum[63:0];
      if (sum > 65'(SAT_MAX)) begin
         r.flag  = 1'b1;
         r.value = SAT_MAX;
      end else if (sum < -65'(SAT_MAX)) begin
         r.flag  = 1'b1;
         r.value = -SAT_MAX;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] coeff_clamp(logic signed [63:0] x);
      if (x > COEFF_LIM) return COEFF_LIM;
      if (x < -COEFF_LIM) return -COEFF_LIM;
      return x;
   endfunction

   // weights of D, V0, V1, A0, A1 in b3, b4, b5
   function automatic logic signed [5:0] mix_coef(logic [2:0] k, logic [2:0] j);
      case (k)
         3'd0: begin
            case (j)
               3'd0:    return 6'sd10;
               3'd1:    return -6'sd6;
               3'd2:    return -6'sd4;
               3'd3:    return -6'sd3;
               3'd4:    return 6'sd1;
               default: return 6'sd0;
            endcase
         end
         3'd1: begin
            case (j)
               3'd0:    return -6'sd15;
               3'd1:    return 6'sd8;
               3'd2:    return 6'sd7;
               3'd3:    return 6'sd3;
               3'd4:    return -6'sd2;
               default: return 6'sd0;
            endcase
         end
         3'd2: begin
            case (j)
               3'd0:    return 6'sd6;
               3'd1:    return -6'sd3;
               3'd2:    return -6'sd3;
               3'd3:    return -6'sd1;
               3'd4:    return 6'sd1;
               default: return 6'sd0;
            endcase
         end
         default: return 6'sd0;
      endcase
   endfunction

   // (j+k)! / j!, weight of b[j+k] in the k-th derivative
   function automatic logic [6:0] fall_coef(logic [2:0] j, logic [2:0] k);
      logic [6:0] f;
      f = 7'd1;
      for (int i = 0; i < 4; i++) begin
         if (i < int'(k)) f = 7'(int'(f) * (int'(j) + int'(k) - i));
      end
      return f;
   endfunction

endpackage

// File: hw/rtl/qts_mul.sv
// Shared rounding multiplier: round(|x| * y / 2^s), saturated, one 32x32 product per cycle.
module qts_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  qts_pkg::unit_req_type req,
   output qts_pkg::unit_rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_LO  = 3'b001,
      PH_HI  = 3'b010,
      PH_SUM = 3'b100
   } phase_type;

   phase_type           phase_ff;
   logic                busy_ff;
   logic [63:0]         m_ff;
   logic                neg_ff;
   logic [31:0]         y_ff;
   qts_pkg::shift_type  sh_ff;
   logic [63:0]         lo_ff;
   logic [63:0]         hi_ff;
   qts_pkg::unit_rsp_type rsp_ff;

   logic [31:0] mult_a;
   logic [63:0] prod;
   logic [95:0] full;
   logic [95:0] rnd;
   logic [95:0] shifted;
   logic [4:0]  amt;
   logic        ovf;
   logic [62:0] magn;

   assign mult_a  = (phase_ff == PH_LO) ? m_ff[31:0] : m_ff[63:32];
   assign prod    = mult_a * y_ff;
   assign amt     = qts_pkg::shift_amount(sh_ff);
   assign full    = {hi_ff, 32'd0} + {32'd0, lo_ff};
   assign rnd     = (amt == 5'd0) ? 96'd0 : (96'd1 << 5'(amt - 5'd1));
   assign shifted = (full + rnd) >> amt;
   assign ovf     = |shifted[95:63];
   assign magn    = ovf ? 63'h7FFF_FFFF_FFFF_FFFF : shifted[62:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         phase_ff   <= PH_LO;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start) begin
            m_ff     <= req.x[63] ? 64'(-req.x) : 64'(req.x);
            neg_ff   <= req.x[63];
            y_ff     <= req.y;
            sh_ff    <= req.sh;
            phase_ff <= PH_LO;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            case (phase_ff)
               PH_LO: begin
                  lo_ff    <= prod;
                  phase_ff <= PH_HI;
               end
               PH_HI: begin
                  hi_ff    <= prod;
                  phase_ff <= PH_SUM;
               end
               PH_SUM: begin
                  rsp_ff.value <= neg_ff ? -$signed({1'b0, magn}) : $signed({1'b0, magn});
                  rsp_ff.flag  <= ovf;
                  rsp_ff.done  <= 1'b1;
                  busy_ff      <= 1'b0;
                  phase_ff     <= PH_LO;
               end
               default: phase_ff <= PH_LO;
            endcase
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: hw/rtl/qts_div.sv
// Shared bit-serial divider: round(|x| * 2^s / d), saturated, one quotient bit per cycle.
module qts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  qts_pkg::unit_req_type req,
   output qts_pkg::unit_rsp_type rsp,
   output logic [63:0]          quotient
);

   logic                 busy_ff;
   logic [6:0]           cnt_ff;
   logic [93:0]          dvd_ff;
   logic [93:0]          quo_ff;
   logic [31:0]          rem_ff;
   logic [31:0]          d_ff;
   logic                 neg_ff;
   qts_pkg::unit_rsp_type rsp_ff;

   logic [32:0] trial;
   logic        ge;
   logic [31:0] rem_in;
   logic        ovf_q;
   logic        rup;
   logic [63:0] q1;
   logic        ovf;
   logic [62:0] magn;

   assign trial  = {rem_ff, dvd_ff[93]};
   assign ge     = trial >= {1'b0, d_ff};
   assign rem_in = ge ? 32'(trial - {1'b0, d_ff}) : trial[31:0];

   // rounding: half away from zero on the remainder
   assign ovf_q = |quo_ff[93:63];
   assign rup   = {rem_ff, 1'b0} >= {1'b0, d_ff};
   assign q1    = {1'b0, quo_ff[62:0]} + {63'd0, rup};
   assign ovf   = ovf_q || q1[63];
   assign magn  = ovf ? 63'h7FFF_FFFF_FFFF_FFFF : q1[62:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= 7'd0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start) begin
            dvd_ff  <= {(req.x[63] ? 64'(-req.x) : 64'(req.x)), 30'd0};
            neg_ff  <= req.x[63];
            d_ff    <= req.y;
            quo_ff  <= 94'd0;
            rem_ff  <= 32'd0;
            cnt_ff  <= 7'(7'd64 + 7'(qts_pkg::shift_amount(req.sh)));
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != 7'd0) begin
               rem_ff <= rem_in;
               quo_ff <= {quo_ff[92:0], ge};
               dvd_ff <= {dvd_ff[92:0], 1'b0};
               cnt_ff <= 7'(cnt_ff - 7'd1);
            end else begin
               rsp_ff.value <= neg_ff ? -$signed({1'b0, magn}) : $signed({1'b0, magn});
               rsp_ff.flag  <= ovf;
               rsp_ff.done  <= 1'b1;
               busy_ff      <= 1'b0;
            end
         end
      end
   end

   assign rsp      = rsp_ff;
   assign quotient = quo_ff[63:0];

endmodule

// File: hw/rtl/quintic_trajectory_sampler_unit.sv
// Quintic trajectory sampler: one full derivative sample per input item.
//
// Input channel req_*: one item per tick; req_restart = 1 starts the move at
// time zero and rebuilds the six quintic coefficients and the sample count.
// Result channel rsp_*: position, velocity, acceleration, jerk and snap in
// Q32.16, the sample time, a last-sample mark and a saturation flag.
// csr_*: eight 32-bit registers; the user must write them only while the
// block is idle, as the block itself does not enforce it. One item is handled
// at a time; req_stall stays high from acceptance until the result is loaded
// into the output register. A sample takes one 94-step divide for u, 20
// scaling and 15 Horner multiplies on the shared multiplier, and ten 80-step
// divides by the duration on the shared bit-serial divider. A restart adds 21
// multiplies and a 65-step divide for the count.
// A finished result sits in the output register while rsp_stall is high; the
// next item is accepted meanwhile, and its result waits until the register
// frees up. Reset clears the control state and loads the register defaults
// (unit duration and period); the first tick after reset acts as a restart.
module quintic_trajectory_sampler_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_position,
   output logic signed [47:0] rsp_velocity,
   output logic signed [47:0] rsp_acceleration,
   output logic signed [47:0] rsp_jerk,
   output logic signed [47:0] rsp_snap,
   output logic [47:0]        rsp_sample_time,
   output logic               rsp_last_sample,
   output logic               rsp_saturated,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   localparam logic [2:0] REG_START_POS = 3'd0;
   localparam logic [2:0] REG_END_POS   = 3'd1;
   localparam logic [2:0] REG_START_VEL = 3'd2;
   localparam logic [2:0] REG_END_VEL   = 3'd3;
   localparam logic [2:0] REG_START_ACC = 3'd4;
   localparam logic [2:0] REG_END_ACC   = 3'd5;
   localparam logic [2:0] REG_DURATION  = 3'd6;
   localparam logic [2:0] REG_PERIOD    = 3'd7;

   localparam int CW = qts_pkg::CNT_WIDTH;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_COEF  = 10'b0000000010,
      ST_MIX   = 10'b0000000100,
      ST_CNT   = 10'b0000001000,
      ST_UDIV  = 10'b0000010000,
      ST_SCALE = 10'b0000100000,
      ST_HMUL  = 10'b0001000000,
      ST_DIVT  = 10'b0010000000,
      ST_STORE = 10'b0100000000,
      ST_OUT   = 10'b1000000000
   } state_type;

   state_type          state_ff;
   logic               go_ff;
   logic [2:0]         cstep_ff;
   logic [2:0]         kidx_ff;
   logic [2:0]         jidx_ff;
   logic [2:0]         dcnt_ff;
   logic [31:0]        cfg_ff [8];
   logic signed [63:0] term_ff [5];
   logic signed [63:0] coef_ff [6];
   logic signed [63:0] acc_ff;
   logic signed [63:0] tmp_ff;
   logic [31:0]        u_ff;
   logic               sat_ff;
   logic signed [47:0] val_ff [5];
   logic               valid_ff;
   logic [47:0]        time_ff;
   logic [CW-1:0]      idx_ff;
   logic [CW-1:0]      count_ff;

   logic               rsp_valid_ff;
   logic signed [47:0] rsp_position_ff;
   logic signed [47:0] rsp_velocity_ff;
   logic signed [47:0] rsp_acceleration_ff;
   logic signed [47:0] rsp_jerk_ff;
   logic signed [47:0] rsp_snap_ff;
   logic [47:0]        rsp_sample_time_ff;
   logic               rsp_last_sample_ff;
   logic               rsp_saturated_ff;

   qts_pkg::unit_req_type mul_req;
   qts_pkg::unit_rsp_type mul_rsp;
   qts_pkg::unit_req_type div_req;
   qts_pkg::unit_rsp_type div_rsp;
   logic [63:0]           div_quot;

   logic               accept;
   logic               out_free;
   logic [31:0]        t_nz;
   logic [31:0]        h_nz;
   logic [2:0]         cidx;
   logic signed [5:0]  mix_val;
   logic [5:0]         mix_abs;
   logic signed [63:0] mix_term;
   qts_pkg::sat_type   mix_sum;
   qts_pkg::sat_type   horner_sum;
   logic [34:0]        n_raw;
   logic [CW-1:0]      count_in;
   logic               coef_at_lim;
   logic signed [47:0] out_val_in;
   logic               out_clip_in;
   logic [CW:0]        idx_next;

   function automatic logic signed [63:0] sx32(logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   qts_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   qts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .rsp      (div_rsp),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign t_nz = (cfg_ff[REG_DURATION] == 32'd0) ? 32'd1 : cfg_ff[REG_DURATION];
   assign h_nz = (cfg_ff[REG_PERIOD] == 32'd0) ? 32'd1 : cfg_ff[REG_PERIOD];

   assign cidx     = 3'(jidx_ff + kidx_ff);
   assign mix_val  = qts_pkg::mix_coef(kidx_ff, jidx_ff);
   assign mix_abs  = (mix_val < 0) ? 6'(-mix_val) : 6'(mix_val);
   assign mix_term = (mix_val < 0) ? -mul_rsp.value : mul_rsp.value;
   assign mix_sum  = qts_pkg::sat_add(acc_ff, mix_term);
   assign horner_sum = qts_pkg::sat_add(tmp_ff, mul_rsp.value);
   assign idx_next = {1'b0, idx_ff} + {{CW{1'b0}}, 1'b1};

   // n = floor((floor(2T/h) + 1) / 2) + 1
   assign n_raw    = (({1'b0, div_quot[33:0]} + 35'd1) >> 1) + 35'd1;
   assign count_in = (n_raw > 35'(qts_pkg::MAX_SAMPLES)) ? CW'(qts_pkg::MAX_SAMPLES)
                                                       : n_raw[CW-1:0];

   always_comb begin
      coef_at_lim = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (coef_ff[i] == qts_pkg::COEFF_LIM || coef_ff[i] == -qts_pkg::COEFF_LIM)
            coef_at_lim = 1'b1;
      end
   end

   always_comb begin
      out_clip_in = 1'b0;
      out_val_in  = acc_ff[47:0];
      if (acc_ff > qts_pkg::OUT_MAX) begin
         out_val_in  = qts_pkg::OUT_MAX[47:0];
         out_clip_in = 1'b1;
      end else if (acc_ff < qts_pkg::OUT_MIN) begin
         out_val_in  = qts_pkg::OUT_MIN[47:0];
         out_clip_in = 1'b1;
      end
   end

   always_comb begin
      mul_req.start = 1'b0;
      mul_req.x     = acc_ff;
      mul_req.y     = u_ff;
      mul_req.sh    = qts_pkg::SHIFT_30;
      case (state_ff)
         ST_COEF: begin
            mul_req.start = go_ff;
            mul_req.y     = t_nz;
            mul_req.sh    = (cstep_ff == 3'd3 || cstep_ff == 3'd5) ? qts_pkg::SHIFT_17
                                                                   : qts_pkg::SHIFT_16;
            case (cstep_ff)
               3'd0:    mul_req.x = sx32(cfg_ff[REG_START_VEL]);
               3'd1:    mul_req.x = sx32(cfg_ff[REG_END_VEL]);
               3'd2:    mul_req.x = sx32(cfg_ff[REG_START_ACC]);
               3'd4:    mul_req.x = sx32(cfg_ff[REG_END_ACC]);
               default: mul_req.x = tmp_ff;
            endcase
         end
         ST_MIX: begin
            mul_req.start = go_ff;
            mul_req.x     = term_ff[jidx_ff];
            mul_req.y     = {26'd0, mix_abs};
            mul_req.sh    = qts_pkg::SHIFT_0;
         end
         ST_SCALE: begin
            mul_req.start = go_ff;
            mul_req.x     = coef_ff[cidx];
            mul_req.y     = {25'd0, qts_pkg::fall_coef(jidx_ff, kidx_ff)};
            mul_req.sh    = qts_pkg::SHIFT_0;
         end
         ST_HMUL: mul_req.start = go_ff;
         default: ;
      endcase
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.x     = acc_ff;
      div_req.y     = t_nz;
      div_req.sh    = qts_pkg::SHIFT_16;
      case (state_ff)
         ST_CNT: begin
            div_req.start = go_ff;
            div_req.x     = {32'd0, t_nz};
            div_req.y     = h_nz;
            div_req.sh    = qts_pkg::SHIFT_1;
         end
         ST_UDIV: begin
            div_req.start = go_ff;
            div_req.x     = {16'd0, time_ff};
            div_req.sh    = qts_pkg::SHIFT_30;
         end
         ST_DIVT: div_req.start = go_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) cfg_ff[i] <= 32'd0;
         cfg_ff[REG_DURATION] <= 32'h0001_0000;
         cfg_ff[REG_PERIOD]   <= 32'h0001_0000;
      end else if (csr_write_enable) begin
         cfg_ff[csr_index] <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         go_ff    <= 1'b0;
         valid_ff <= 1'b0;
         time_ff  <= 48'd0;
         idx_ff   <= '0;
         count_ff <= '0;
         cstep_ff <= 3'd0;
         kidx_ff  <= 3'd0;
         jidx_ff  <= 3'd0;
         dcnt_ff  <= 3'd0;
      end else begin
         go_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  go_ff <= 1'b1;
                  if (req_restart || !valid_ff) begin
                     idx_ff     <= '0;
                     time_ff    <= 48'd0;
                     cstep_ff   <= 3'd0;
                     term_ff[0] <= sx32(cfg_ff[REG_END_POS]) - sx32(cfg_ff[REG_START_POS]);
                     coef_ff[0] <= qts_pkg::coeff_clamp(sx32(cfg_ff[REG_START_POS]));
                     state_ff   <= ST_COEF;
                  end else begin
                     if (idx_next < {1'b0, count_ff}) begin
                        idx_ff  <= idx_next[CW-1:0];
                        time_ff <= 48'(time_ff + {16'd0, h_nz});
                     end
                     state_ff <= ST_UDIV;
                  end
               end
            end
            ST_COEF: begin
               if (mul_rsp.done) begin
                  go_ff <= 1'b1;
                  case (cstep_ff)
                     3'd0: begin
                        term_ff[1] <= mul_rsp.value;
                        coef_ff[1] <= qts_pkg::coeff_clamp(mul_rsp.value);
                     end
                     3'd1: term_ff[2] <= mul_rsp.value;
                     3'd3: begin
                        term_ff[3] <= mul_rsp.value;
                        coef_ff[2] <= qts_pkg::coeff_clamp(mul_rsp.value);
                     end
                     3'd5: term_ff[4] <= mul_rsp.value;
                     default: tmp_ff <= mul_rsp.value;
                  endcase
                  if (cstep_ff == 3'd5) begin
                     kidx_ff  <= 3'd0;
                     jidx_ff  <= 3'd0;
                     acc_ff   <= 64'sd0;
                     state_ff <= ST_MIX;
                  end else begin
                     cstep_ff <= 3'(cstep_ff + 3'd1);
                  end
               end
            end
            ST_MIX: begin
               if (mul_rsp.done) begin
                  go_ff <= 1'b1;
                  if (jidx_ff == 3'd4) begin
                     coef_ff[3'(kidx_ff + 3'd3)] <= qts_pkg::coeff_clamp(mix_sum.value);
                     acc_ff  <= 64'sd0;
                     jidx_ff <= 3'd0;
                     if (kidx_ff == 3'd2) state_ff <= ST_CNT;
                     else kidx_ff <= 3'(kidx_ff + 3'd1);
                  end else begin
                     acc_ff  <= mix_sum.value;
                     jidx_ff <= 3'(jidx_ff + 3'd1);
                  end
               end
            end
            ST_CNT: begin
               if (div_rsp.done) begin
                  count_ff <= count_in;
                  valid_ff <= 1'b1;
                  go_ff    <= 1'b1;
                  state_ff <= ST_UDIV;
               end
            end
            ST_UDIV: begin
               if (div_rsp.done) begin
                  u_ff     <= (div_rsp.value > qts_pkg::U_LIMIT) ? qts_pkg::U_LIMIT[31:0]
                                                                 : div_rsp.value[31:0];
                  sat_ff   <= coef_at_lim;
                  kidx_ff  <= 3'd0;
                  jidx_ff  <= 3'd5;
                  go_ff    <= 1'b1;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               if (mul_rsp.done) begin
                  // first term of the Horner chain starts the sum
                  if (jidx_ff == 3'(3'd5 - kidx_ff)) begin
                     acc_ff <= mul_rsp.value;
                     sat_ff <= sat_ff | mul_rsp.flag;
                  end else begin
                     acc_ff <= horner_sum.value;
                     sat_ff <= sat_ff | mul_rsp.flag | horner_sum.flag;
                  end
                  if (jidx_ff == 3'd0) begin
                     dcnt_ff  <= 3'd0;
                     if (kidx_ff == 3'd0) begin
                        state_ff <= ST_STORE;
                     end else begin
                        go_ff    <= 1'b1;
                        state_ff <= ST_DIVT;
                     end
                  end else begin
                     jidx_ff  <= 3'(jidx_ff - 3'd1);
                     go_ff    <= 1'b1;
                     state_ff <= ST_HMUL;
                  end
               end
            end
            ST_HMUL: begin
               if (mul_rsp.done) begin
                  tmp_ff   <= mul_rsp.value;
                  sat_ff   <= sat_ff | mul_rsp.flag;
                  go_ff    <= 1'b1;
                  state_ff <= ST_SCALE;
               end
            end
            ST_DIVT: begin
               if (div_rsp.done) begin
                  acc_ff <= div_rsp.value;
                  sat_ff <= sat_ff | div_rsp.flag;
                  if (3'(dcnt_ff + 3'd1) == kidx_ff) begin
                     state_ff <= ST_STORE;
                  end else begin
                     dcnt_ff <= 3'(dcnt_ff + 3'd1);
                     go_ff   <= 1'b1;
                  end
               end
            end
            ST_STORE: begin
               val_ff[kidx_ff] <= out_val_in;
               sat_ff          <= sat_ff | out_clip_in;
               if (kidx_ff == 3'd4) begin
                  state_ff <= ST_OUT;
               end else begin
                  kidx_ff  <= 3'(kidx_ff + 3'd1);
                  jidx_ff  <= 3'(3'd4 - kidx_ff);
                  go_ff    <= 1'b1;
                  state_ff <= ST_SCALE;
               end
            end
            ST_OUT: begin
               if (out_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff        <= 1'b1;
         rsp_position_ff     <= val_ff[0];
         rsp_velocity_ff     <= val_ff[1];
         rsp_acceleration_ff <= val_ff[2];
         rsp_jerk_ff         <= val_ff[3];
         rsp_snap_ff         <= val_ff[4];
         rsp_sample_time_ff  <= time_ff;
         rsp_last_sample_ff  <= (idx_next >= {1'b0, count_ff});
         rsp_saturated_ff    <= sat_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_velocity     = rsp_velocity_ff;
   assign rsp_acceleration = rsp_acceleration_ff;
   assign rsp_jerk         = rsp_jerk_ff;
   assign rsp_snap         = rsp_snap_ff;
   assign rsp_sample_time  = rsp_sample_time_ff;
   assign rsp_last_sample  = rsp_last_sample_ff;
   assign rsp_saturated    = rsp_saturated_ff;

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_req.start && div_req.start))
      else $error("multiplier and divider started together");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff < count_ff)
      else $error("sample index past sample count");

   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(time_ff))
      else $error("sample time moved without an item");

   a_mul_owner: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == ST_COEF || state_ff == ST_MIX ||
                        state_ff == ST_SCALE || state_ff == ST_HMUL))
      else $error("multiplier result with no consumer");

endmodule
